// ===== hdl/nsp_pkg.sv =====
// Shared types, constants and helpers for the nested section profiler.
// Used by nsp_table_ram, nsp_frame_stack and nested_section_profiler.
package nsp_pkg;

    // Sizes of the section table and the frame stack
    localparam int SECTION_COUNT = 4096;
    localparam int STACK_DEPTH   = 16;

    localparam int TBL_AW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int FRM_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int SEC_W  = 12;
    localparam int BYTE_W = 32;
    localparam int CNT_W  = 64;
    localparam int ST_W   = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW   = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_SECTION = 2'd3;

    // One row of the section table
    typedef struct packed {
        logic [CNT_W-1:0] incl;
        logic [CNT_W-1:0] excl;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] bytes;
        logic             seen;
    } t_row;

    // One stack frame
    typedef struct packed {
        logic [TBL_AW-1:0] section;
        logic [TBL_AW-1:0] parent;
        logic [CNT_W-1:0]  start;
        logic [CNT_W-1:0]  prev_incl;
    } t_frame;

    // Stack command from the sequencer
    typedef struct packed {
        logic   push;
        logic   pop;
        t_frame frame;
    } t_stack_cmd;

    // Table address of a section number
    function automatic logic [TBL_AW-1:0] sec_addr(input logic [SEC_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[TBL_AW-1:0];
    endfunction

    // Section 0 is the root and cannot be entered or read
    function automatic logic sec_good(input logic [SEC_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return (idx != '0) && (wide < 32'(SECTION_COUNT));
    endfunction

endpackage

// ===== hdl/nsp_table_ram.sv =====
// Section table: one row of totals per section, simple dual port,
// registered read. Depends on nsp_pkg for the row type and depth.
module nsp_table_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [nsp_pkg::TBL_AW-1:0] i_waddr,
    input  nsp_pkg::t_row         i_wdata,
    input  logic                  i_re,
    input  logic [nsp_pkg::TBL_AW-1:0] i_raddr,
    output nsp_pkg::t_row         o_rdata
);
    import nsp_pkg::*;

    t_row r_mem [SECTION_COUNT];
    t_row r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/nsp_frame_stack.sv =====
// Frame stack of entered sections plus the active section register.
// Depends on nsp_pkg for the frame and command types.
module nsp_frame_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsp_pkg::t_stack_cmd       i_cmd,
    output nsp_pkg::t_frame           o_top,
    output logic [nsp_pkg::LVL_W-1:0] o_level,
    output logic [nsp_pkg::TBL_AW-1:0] o_active
);
    import nsp_pkg::*;

    t_frame            r_frames [STACK_DEPTH];
    logic [LVL_W-1:0]  r_level;
    logic [TBL_AW-1:0] r_active;
    logic [LVL_W-1:0]  w_top_lvl;
    logic [FRM_AW-1:0] w_top_idx;
    logic [FRM_AW-1:0] w_push_idx;

    assign w_top_lvl  = r_level - 1'b1;
    assign w_top_idx  = w_top_lvl[FRM_AW-1:0];
    assign w_push_idx = r_level[FRM_AW-1:0];

    // Frame storage, no reset: an unpushed frame's contents are never used
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_frames[w_push_idx] <= i_cmd.frame;
        end
    end

    // Level and active section
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_active <= '0;
        end else if (i_cmd.push) begin
            r_level  <= r_level + 1'b1;
            r_active <= i_cmd.frame.section;
        end else if (i_cmd.pop) begin
            r_level  <= w_top_lvl;
            r_active <= r_frames[w_top_idx].parent;
        end
    end

    assign o_top    = r_frames[w_top_idx];
    assign o_level  = r_level;
    assign o_active = r_active;

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_level < LVL_W'(STACK_DEPTH)))
        else $error("push on full stack");
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_level != '0))
        else $error("pop on empty stack");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop together");
    a_pop_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_level == $past(r_level) - 1'b1))
        else $error("pop did not lower level");
`endif

endmodule

// ===== hdl/nested_section_profiler.sv =====
// Nested section profiler: input items enter, exit or read code sections and
// each gives one result: the section's totals after the update, or zeros on error.
// Input channel: i_in_valid/o_in_ready with opcode, section index, byte count
// and timestamp. Output channel: o_out_valid/i_out_ready with status,
// inclusive, exclusive, hit count, byte total and seen flag.
// Totals live in a 4096-row table RAM with a registered read; the
// item is accepted in the cycle its row read is issued.
// Sequence: an accepted item goes to S_MOD, which waits for a free output
// register, writes the row of a valid enter or exit, and loads the result;
// an exit then updates its parent's row in S_PAR, unless the parent is the
// section itself. A new item is accepted only back in S_IDLE, once the last
// one is through; S_PAR exists since the RAM has a single write port.
// Reset: synchronous active-low reset empties the stack, makes the root
// active and then clears the table, one row a cycle from 0 to 4095, during
// which o_in_ready stays low.
// Stall: a finished result waits in an output register; the next item is
// still accepted, and its own result waits until the register is taken.
// Depends on nsp_pkg, nsp_table_ram and nsp_frame_stack.
module nested_section_profiler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [nsp_pkg::OP_W-1:0]   i_opcode,
    input  logic [nsp_pkg::SEC_W-1:0]  i_section_index,
    input  logic [nsp_pkg::BYTE_W-1:0] i_byte_count,
    input  logic [nsp_pkg::CNT_W-1:0]  i_timestamp,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [nsp_pkg::ST_W-1:0]   o_status,
    output logic [nsp_pkg::CNT_W-1:0]  o_inclusive_cycles,
    output logic [nsp_pkg::CNT_W-1:0]  o_exclusive_cycles,
    output logic [nsp_pkg::CNT_W-1:0]  o_hit_count,
    output logic [nsp_pkg::CNT_W-1:0]  o_bytes_total,
    output logic                       o_seen
);
    import nsp_pkg::*;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_MOD  = 4'b0100,
        S_PAR  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Latched item
    logic [OP_W-1:0]   r_op;
    logic [SEC_W-1:0]  r_sec;
    logic [BYTE_W-1:0] r_bytes;
    logic [CNT_W-1:0]  r_ts;
    logic [CNT_W-1:0]  r_elapsed;
    logic [TBL_AW-1:0] r_par;
    logic [TBL_AW-1:0] r_clr_addr;

    // Output register
    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    t_row              r_out_row;

    // Table RAM and stack
    logic              w_we, w_re;
    logic [TBL_AW-1:0] w_waddr, w_raddr;
    t_row              w_wdata, w_rdata;
    t_stack_cmd        w_cmd;
    t_frame            w_top;
    logic [LVL_W-1:0]  w_level;
    logic [TBL_AW-1:0] w_active;

    // Modify-step decode
    logic              w_accept, w_slot_free, w_fire;
    logic              w_good, w_full, w_empty;
    logic [ST_W-1:0]   w_status;
    logic              w_show, w_mod_we, w_go_par, w_push, w_pop;
    logic [TBL_AW-1:0] w_mod_addr;
    t_row              w_mod_row;
    t_row              w_par_row;

    nsp_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nsp_frame_stack u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_top    (w_top),
        .o_level  (w_level),
        .o_active (w_active)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_fire      = (r_state == S_MOD) && w_slot_free;

    assign w_good  = sec_good(r_sec);
    assign w_full  = (w_level == LVL_W'(STACK_DEPTH));
    assign w_empty = (w_level == '0);

    // Decode of the latched item against the read row and stack top
    always_comb begin
        w_status   = ST_OK;
        w_show     = 1'b0;
        w_mod_we   = 1'b0;
        w_go_par   = 1'b0;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_mod_addr = sec_addr(r_sec);
        w_mod_row  = w_rdata;
        unique case (r_op)
            OP_ENTER: begin
                if (!w_good) begin
                    w_status = ST_BAD_SECTION;
                end else if (w_full) begin
                    w_status = ST_OVERFLOW;
                end else begin
                    w_show          = 1'b1;
                    w_mod_we        = 1'b1;
                    w_push          = 1'b1;
                    w_mod_row.bytes = w_rdata.bytes + CNT_W'(r_bytes);
                end
            end
            OP_EXIT: begin
                if (w_empty) begin
                    w_status = ST_UNDERFLOW;
                end else begin
                    w_show         = 1'b1;
                    w_mod_we       = 1'b1;
                    w_pop          = 1'b1;
                    w_mod_addr     = w_top.section;
                    w_mod_row.incl = w_top.prev_incl + r_elapsed;
                    w_mod_row.hits = w_rdata.hits + 1'b1;
                    w_mod_row.seen = 1'b1;
                    // recursive exit: add and subtract cancel on one row
                    if (w_top.section != w_top.parent) begin
                        w_mod_row.excl = w_rdata.excl + r_elapsed;
                        w_go_par       = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (!w_good) begin
                    w_status = ST_BAD_SECTION;
                end else begin
                    w_show = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Parent row: exclusive loses the child's elapsed time
    always_comb begin
        w_par_row      = w_rdata;
        w_par_row.excl = w_rdata.excl - r_elapsed;
    end

    // Stack commands
    always_comb begin
        w_cmd.push            = w_fire && w_push;
        w_cmd.pop             = w_fire && w_pop;
        w_cmd.frame.section   = sec_addr(r_sec);
        w_cmd.frame.parent    = w_active;
        w_cmd.frame.start     = r_ts;
        w_cmd.frame.prev_incl = w_rdata.incl;
    end

    // RAM port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_mod_addr;
        w_wdata = w_mod_row;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_MOD: begin
                w_we = w_fire && w_mod_we;
            end
            S_PAR: begin
                w_we    = 1'b1;
                w_waddr = r_par;
                w_wdata = w_par_row;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        w_re    = w_accept || (w_fire && w_go_par);
        w_raddr = w_accept ? ((i_opcode == OP_EXIT) ? w_top.section
                                                     : sec_addr(i_section_index))
                           : w_top.parent;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_addr == TBL_AW'(SECTION_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_fire) begin
                    n_state = w_go_par ? S_PAR : S_IDLE;
                end
            end
            S_PAR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_opcode;
            r_sec     <= i_section_index;
            r_bytes   <= i_byte_count;
            r_ts      <= i_timestamp;
            r_elapsed <= i_timestamp - w_top.start;
        end
        if (w_fire) begin
            r_par        <= w_top.parent;
            r_out_status <= w_status;
            r_out_row    <= w_show ? w_mod_row : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_inclusive_cycles = r_out_row.incl;
    assign o_exclusive_cycles = r_out_row.excl;
    assign o_hit_count        = r_out_row.hits;
    assign o_bytes_total      = r_out_row.bytes;
    assign o_seen             = r_out_row.seen;

`ifndef SYNTH
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("table written while idle");
    a_par_is_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAR) |-> (r_op == OP_EXIT))
        else $error("parent update outside exit");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            ((o_inclusive_cycles == '0) && (o_hit_count == '0) && !o_seen))
        else $error("error result carries totals");
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("finished item not presented");
`endif

endmodule

// ===== sim/tb_nested_section_profiler.sv =====
// Testbench for nested_section_profiler: a queue-fed driver and a checking
// monitor around the block, with an in-bench model of the section totals.
// Depends on nsp_pkg and the nested_section_profiler RTL.
module tb_nested_section_profiler;
    import nsp_pkg::*;

    // Opcode 3 has no name in the package; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1850;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 100;

    // Traffic phases: idle percentages of sender and receiver
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SEC_W-1:0]  sec;
        logic [BYTE_W-1:0] nbytes;
        logic [CNT_W-1:0]  stamp;
        int                phase;
    } t_profile_item;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] incl;
        logic [CNT_W-1:0] excl;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] nbytes;
        logic             seen;
    } t_section_totals;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_opcode = '0;
    logic [SEC_W-1:0]   i_section_index = '0;
    logic [BYTE_W-1:0]  i_byte_count = '0;
    logic [CNT_W-1:0]   i_timestamp = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [ST_W-1:0]    o_status;
    logic [CNT_W-1:0]   o_inclusive_cycles;
    logic [CNT_W-1:0]   o_exclusive_cycles;
    logic [CNT_W-1:0]   o_hit_count;
    logic [CNT_W-1:0]   o_bytes_total;
    logic               o_seen;

    nested_section_profiler DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_section_index    (i_section_index),
        .i_byte_count       (i_byte_count),
        .i_timestamp        (i_timestamp),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_inclusive_cycles (o_inclusive_cycles),
        .o_exclusive_cycles (o_exclusive_cycles),
        .o_hit_count        (o_hit_count),
        .o_bytes_total      (o_bytes_total),
        .o_seen             (o_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_profile_item   pending_events[$];
    t_section_totals expected_totals[$];

    // Model state: section table and frame stack
    logic [CNT_W-1:0]  incl_tbl[SECTION_COUNT];
    logic [CNT_W-1:0]  excl_tbl[SECTION_COUNT];
    logic [CNT_W-1:0]  hits_tbl[SECTION_COUNT];
    logic [CNT_W-1:0]  bytes_tbl[SECTION_COUNT];
    logic              seen_tbl[SECTION_COUNT];
    logic [SEC_W-1:0]  active_sec;
    logic [SEC_W-1:0]  frm_sec[STACK_DEPTH];
    logic [SEC_W-1:0]  frm_parent[STACK_DEPTH];
    logic [CNT_W-1:0]  frm_start[STACK_DEPTH];
    logic [CNT_W-1:0]  frm_prev_incl[STACK_DEPTH];
    int unsigned       stack_lvl;

    int  n_enter, n_exit, n_read, n_unused, n_flagged, deepest, recursive_exits;
    int  mismatches;
    int  results_seen;
    int  cur_phase;
    int  idle_cycles;

    initial begin
        for (int k = 0; k < SECTION_COUNT; k++) begin
            incl_tbl[k] = '0;
            excl_tbl[k] = '0;
            hits_tbl[k] = '0;
            bytes_tbl[k] = '0;
            seen_tbl[k] = 1'b0;
        end
        active_sec = '0;
        stack_lvl = 0;
        n_enter = 0; n_exit = 0; n_read = 0; n_unused = 0;
        n_flagged = 0; deepest = 0; recursive_exits = 0;
        mismatches = 0; results_seen = 0; cur_phase = PH_NONE; idle_cycles = 0;
    end

    // Totals of one section as reported after the update
    function automatic t_section_totals section_report(input logic [SEC_W-1:0] sec);
        t_section_totals r;
        r.status = ST_OK;
        r.incl   = incl_tbl[sec];
        r.excl   = excl_tbl[sec];
        r.hits   = hits_tbl[sec];
        r.nbytes = bytes_tbl[sec];
        r.seen   = seen_tbl[sec];
        return r;
    endfunction

    // Apply one accepted item to the model and queue the result it gives
    function automatic void predict_totals(input t_profile_item ev);
        t_section_totals  res;
        logic [SEC_W-1:0] sec;
        logic [SEC_W-1:0] par;
        logic [CNT_W-1:0] elapsed;
        int unsigned      lvl;
        res = '{ST_OK, '0, '0, '0, '0, 1'b0};
        case (ev.op)
            OP_ENTER: begin
                n_enter++;
                if (ev.sec == '0) begin
                    res.status = ST_BAD_SECTION;
                end else if (stack_lvl >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    lvl = stack_lvl;
                    frm_sec[lvl] = ev.sec;
                    frm_parent[lvl] = active_sec;
                    frm_start[lvl] = ev.stamp;
                    frm_prev_incl[lvl] = incl_tbl[ev.sec];
                    bytes_tbl[ev.sec] = bytes_tbl[ev.sec] + CNT_W'(ev.nbytes);
                    active_sec = ev.sec;
                    stack_lvl = lvl + 1;
                    if (stack_lvl > deepest) deepest = stack_lvl;
                    res = section_report(ev.sec);
                end
            end
            OP_EXIT: begin
                n_exit++;
                if (stack_lvl == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    lvl = stack_lvl - 1;
                    sec = frm_sec[lvl];
                    par = frm_parent[lvl];
                    if (sec == par) recursive_exits++;
                    elapsed = ev.stamp - frm_start[lvl];
                    stack_lvl = lvl;
                    active_sec = par;
                    // parent loses the child's time, child gains it
                    excl_tbl[par] = excl_tbl[par] - elapsed;
                    excl_tbl[sec] = excl_tbl[sec] + elapsed;
                    incl_tbl[sec] = frm_prev_incl[lvl] + elapsed;
                    hits_tbl[sec] = hits_tbl[sec] + CNT_W'(1);
                    seen_tbl[sec] = 1'b1;
                    res = section_report(sec);
                end
            end
            OP_READ: begin
                n_read++;
                if (ev.sec == '0) res.status = ST_BAD_SECTION;
                else res = section_report(ev.sec);
            end
            default: n_unused++;
        endcase
        if (res.status != ST_OK) n_flagged++;
        expected_totals.push_back(res);
    endfunction

    function automatic bit roll_idle(input int phase, input bit sender);
        int pct;
        pct = 0;
        if (phase == PH_BOTH) pct = 38;
        else if (sender && phase == PH_SEND) pct = 59;
        else if (!sender && phase == PH_RECV) pct = 59;
        return $urandom_range(99) < pct;
    endfunction

    // Driver: presents the head of the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_totals(pending_events[0]);
                cur_phase <= pending_events[0].phase;
                void'(pending_events.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_events.size() > 0 && !roll_idle(pending_events[0].phase, 1'b1)) begin
                    i_in_valid      <= 1'b1;
                    i_opcode        <= pending_events[0].op;
                    i_section_index <= pending_events[0].sec;
                    i_byte_count    <= pending_events[0].nbytes;
                    i_timestamp     <= pending_events[0].stamp;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [CNT_W-1:0] exp_v,
                                        input logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endfunction

    // Monitor: checks each result item against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_totals.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $error("result item with no prediction pending");
                end else begin
                    check_field("status", CNT_W'(expected_totals[0].status), CNT_W'(o_status));
                    check_field("inclusive_cycles", expected_totals[0].incl, o_inclusive_cycles);
                    check_field("exclusive_cycles", expected_totals[0].excl, o_exclusive_cycles);
                    check_field("hit_count", expected_totals[0].hits, o_hit_count);
                    check_field("bytes_total", expected_totals[0].nbytes, o_bytes_total);
                    check_field("seen", CNT_W'(expected_totals[0].seen), CNT_W'(o_seen));
                    void'(expected_totals.pop_front());
                end
            end
            i_out_ready <= !roll_idle(cur_phase, 1'b0);
        end
    end

    // Watchdog on cycles without any handshake; covers the table clear
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[nested_section_profiler] ERROR");
            $finish;
        end
    end

    task automatic queue_event(input logic [OP_W-1:0] op, input logic [SEC_W-1:0] sec,
                               input logic [BYTE_W-1:0] nbytes, input logic [CNT_W-1:0] stamp,
                               input int phase);
        t_profile_item ev;
        ev.op = op;
        ev.sec = sec;
        ev.nbytes = nbytes;
        ev.stamp = stamp;
        ev.phase = phase;
        pending_events.push_back(ev);
    endtask

    // Stimulus: directed corners, then nested random traffic
    initial begin
        logic [CNT_W-1:0]  clock_now;
        logic [SEC_W-1:0]  sec;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] nbytes;
        int                gen_depth;
        int                phase;
        int                r;
        bit                dive;

        // error cases and the unused opcode with every bit set
        queue_event(OP_EXIT, '0, '0, 64'd1, PH_NONE);
        queue_event(OP_READ, '0, '0, '0, PH_NONE);
        queue_event(OP_ENTER, '0, 32'd5, 64'd7, PH_NONE);
        queue_event(OP_UNUSED, '1, '1, '1, PH_NONE);
        queue_event(OP_READ, 12'd4095, '0, '0, PH_NONE);
        // recursion of one section, with the outer elapsed time wrapping
        queue_event(OP_ENTER, 12'd7, '1, 64'hFFFF_FFFF_FFFF_FFFA, PH_NONE);
        queue_event(OP_ENTER, 12'd7, '1, 64'd3, PH_NONE);
        queue_event(OP_EXIT, '0, '0, 64'd10, PH_NONE);
        queue_event(OP_EXIT, '0, '0, 64'd2, PH_NONE);
        queue_event(OP_READ, 12'd7, '0, '0, PH_NONE);
        // fill the stack, then one enter too many
        for (int k = 0; k < STACK_DEPTH; k++)
            queue_event(OP_ENTER, (k == 0) ? 12'd4095 : SEC_W'(k), BYTE_W'(k),
                        CNT_W'(100 + 10 * k), PH_NONE);
        queue_event(OP_ENTER, 12'd9, 32'd1, 64'd500, PH_NONE);
        gen_depth = STACK_DEPTH;

        clock_now = {$urandom, $urandom};
        dive = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase = i * 4 / RANDOM_ITEMS;
            if ($urandom_range(29) == 0) dive = !dive;
            // timestamps mostly advance; now and then jump or step back
            r = $urandom_range(99);
            if (r < 3) clock_now = {$urandom, $urandom};
            else if (r < 5) clock_now = clock_now - CNT_W'($urandom_range(1, 500));
            else clock_now = clock_now + CNT_W'($urandom_range(0, 300));
            nbytes = ($urandom_range(9) < 7) ? BYTE_W'($urandom) : BYTE_W'($urandom_range(16));
            sec = ($urandom_range(3) != 0) ? SEC_W'($urandom_range(1, 12))
                                           : SEC_W'($urandom_range(1, 4095));
            r = $urandom_range(99);
            if (r < 6) begin
                // noise: unused opcode, root section, or a stack error
                case ($urandom_range(2))
                    0: begin
                        op = OP_UNUSED;
                        sec = SEC_W'($urandom);
                    end
                    1: begin
                        op = $urandom_range(1) ? OP_ENTER : OP_READ;
                        sec = '0;
                    end
                    default: begin
                        if (gen_depth == 0) op = OP_EXIT;
                        else if (gen_depth == STACK_DEPTH) op = OP_ENTER;
                        else op = OP_UNUSED;
                    end
                endcase
            end else if (r < 21) begin
                op = OP_READ;
            end else begin
                op = ($urandom_range(99) < (dive ? 65 : 35)) ? OP_ENTER : OP_EXIT;
                if (op == OP_ENTER && gen_depth == STACK_DEPTH && $urandom_range(9) != 0)
                    op = OP_EXIT;
                if (op == OP_EXIT && gen_depth == 0) op = OP_ENTER;
                if (op == OP_ENTER && gen_depth < STACK_DEPTH) gen_depth++;
                else if (op == OP_EXIT) gen_depth--;
            end
            queue_event(op, sec, nbytes, clock_now, phase);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0 || expected_totals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d enters, %0d exits (%0d recursive), %0d reads, %0d unused opcodes;",
                 n_enter, n_exit, recursive_exits, n_read, n_unused);
        $display("%0d results checked, %0d flagged, deepest nesting %0d, %0d mismatches",
                 results_seen, n_flagged, deepest, mismatches);
        if (mismatches == 0 && expected_totals.size() == 0) begin
            $display("[nested_section_profiler] OK");
        end else begin
            $display("[nested_section_profiler] ERROR");
        end
        $finish;
    end

endmodule
